// ===== rtl/core/cam_pkg.sv =====
// ----------------------------------------------------------------------------
// cam_pkg: shared types and constants of the CSI amplitude motion detector
// Item types of both channels, the configuration set and its register
// indexes, reset values and the sample magnitude helper.
// ----------------------------------------------------------------------------
package cam_pkg;

    localparam int AMP_W       = 14;
    localparam int AMP_MAX     = 16383;
    localparam int SAMPLE_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAKS_TRIGGER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN      = 2'd3;

    localparam logic [13:0] RST_DEV_THRESHOLD = 14'd45;
    localparam logic [7:0]  RST_PEAKS_TRIGGER = 8'd5;
    localparam logic [15:0] RST_TIME_WINDOW   = 16'd50;
    localparam logic [15:0] RST_COOLDOWN      = 16'd100;

    localparam logic [7:0]  PEAK_CNT_MAX   = 8'hFF;
    localparam logic [15:0] WINDOW_CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] imag_part;
        logic signed [SAMPLE_W-1:0] real_part;
        logic                       pair_valid;
        logic                       frame_end;
    } sample_t;

    typedef struct packed {
        logic [AMP_W-1:0] frame_amplitude;
        logic [AMP_W-1:0] window_average;
        logic [AMP_W-1:0] amplitude_deviation;
        logic             motion_detected;
        logic             cooling_down;
    } result_t;

    typedef struct packed {
        logic [13:0] deviation_threshold;
        logic [7:0]  peaks_to_trigger;
        logic [15:0] window_limit;
        logic [15:0] cooldown_limit;
    } cfg_t;

    function automatic logic [SAMPLE_W-1:0] mag8(input logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] u;
        u = v;
        return u[SAMPLE_W-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

// ===== rtl/core/cam_ram.sv =====
// ----------------------------------------------------------------------------
// cam_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module cam_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/cam_front.sv =====
// ----------------------------------------------------------------------------
// cam_front: frame accumulator
// Sums |I|+|Q| of the valid pairs of a frame up to the pair limit, with
// saturation, and hands the frame amplitude on at the end of the frame.
// ----------------------------------------------------------------------------
module cam_front #(
    parameter int MAX_PAIRS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  cam_pkg::sample_t           sample,
    output logic                       push,
    output logic [cam_pkg::AMP_W-1:0]  push_amp
);

    localparam int PAIR_W = $clog2(MAX_PAIRS + 1);

    logic [cam_pkg::AMP_W-1:0] acc_reg, acc_next, acc_upd;
    logic [PAIR_W-1:0]         pairs_reg, pairs_next, pairs_upd;
    logic                      count_ok;
    logic [cam_pkg::AMP_W:0]   sum;

    always_comb
    begin
        count_ok = sample.pair_valid && (pairs_reg < PAIR_W'(MAX_PAIRS));
        sum = {1'b0, acc_reg}
            + (cam_pkg::AMP_W + 1)'(cam_pkg::mag8(sample.imag_part))
            + (cam_pkg::AMP_W + 1)'(cam_pkg::mag8(sample.real_part));
        if (count_ok)
        begin
            acc_upd   = (sum > (cam_pkg::AMP_W + 1)'(cam_pkg::AMP_MAX))
                      ? cam_pkg::AMP_W'(cam_pkg::AMP_MAX) : sum[cam_pkg::AMP_W-1:0];
            pairs_upd = pairs_reg + 1'b1;
        end
        else
        begin
            acc_upd   = acc_reg;
            pairs_upd = pairs_reg;
        end

        acc_next   = acc_reg;
        pairs_next = pairs_reg;
        if (take)
        begin
            if (sample.frame_end)
            begin
                acc_next   = '0;
                pairs_next = '0;
            end
            else
            begin
                acc_next   = acc_upd;
                pairs_next = pairs_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            pairs_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            pairs_reg <= pairs_next;
        end
    end

    assign push     = take && sample.frame_end;
    assign push_amp = acc_upd;

endmodule

// ===== rtl/core/cam_queue.sv =====
// ----------------------------------------------------------------------------
// cam_queue: frame amplitude queue
// Short register FIFO between the accumulator and the detection pipeline.
// ----------------------------------------------------------------------------
module cam_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [cam_pkg::AMP_W-1:0]  push_data,
    output logic                       full,
    input  logic                       pop,
    output logic [cam_pkg::AMP_W-1:0]  pop_data,
    output logic                       empty
);

    localparam int PTR_W = $clog2(cam_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cam_pkg::QUEUE_DEPTH + 1);

    logic [cam_pkg::AMP_W-1:0] slot_reg [cam_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]          count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full     = (count_reg == CNT_W'(cam_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/cam_back.sv =====
// ----------------------------------------------------------------------------
// cam_back: window and detection pipeline
// Ring read, running total, reciprocal average, deviation, then the
// cooldown, peak and time-window counters and the result register.
// ----------------------------------------------------------------------------
module cam_back #(
    parameter int WINDOW = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cam_pkg::cfg_t              cfg,
    input  logic                       q_empty,
    input  logic [cam_pkg::AMP_W-1:0]  q_data,
    output logic                       q_pop,
    output logic                       result_valid,
    input  logic                       result_stall,
    output cam_pkg::result_t           result
);

    localparam int AW      = cam_pkg::AMP_W;
    localparam int POS_W   = $clog2(WINDOW);
    localparam int SEEN_W  = $clog2(WINDOW + 1);
    localparam int TOT_W   = $clog2(WINDOW * cam_pkg::AMP_MAX + 1);
    localparam int SHIFT   = TOT_W + $clog2(WINDOW);
    localparam int RECIP_W = TOT_W + 2;
    localparam int PROD_W  = TOT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic              advance;
    logic [POS_W-1:0]  pos_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic              warm0;

    logic              s1_valid_reg, s1_warm_reg;
    logic [AW-1:0]     s1_amp_reg;
    logic [POS_W-1:0]  s1_pos_reg;
    logic [AW-1:0]     ring_rd, ring_old;
    logic [TOT_W-1:0]  total_reg, total_next;

    logic              s2_valid_reg, s2_warm_reg;
    logic [AW-1:0]     s2_amp_reg;

    logic              s3_valid_reg, s3_warm_reg;
    logic [AW-1:0]     s3_amp_reg;
    logic [PROD_W-1:0] s3_prod_reg;
    logic [AW-1:0]     avg;

    logic              s4_valid_reg, s4_warm_reg;
    logic [AW-1:0]     s4_amp_reg, s4_avg_reg, s4_dev_reg;

    logic [7:0]        peak_reg, peak_next, peak_upd;
    logic [15:0]       wcnt_reg, wcnt_next, wcnt_upd;
    logic [15:0]       cool_reg, cool_next;
    logic              cooling, trigger, window_done, do_ctl;

    logic              result_valid_reg, result_valid_next;
    cam_pkg::result_t  result_reg;

    assign advance = !result_valid_reg || !result_stall;
    assign q_pop   = advance && !q_empty;
    assign warm0   = (seen_reg == SEEN_W'(WINDOW));

    cam_ram #(
        .WIDTH (AW),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (advance && s1_valid_reg),
        .wr_addr (s1_pos_reg),
        .wr_data (s1_amp_reg),
        .rd_en   (q_pop),
        .rd_addr (pos_reg),
        .rd_data (ring_rd)
    );

    assign ring_old   = s1_warm_reg ? ring_rd : '0;
    assign total_next = total_reg - TOT_W'(ring_old) + TOT_W'(s1_amp_reg);
    assign avg        = s3_prod_reg[SHIFT +: AW];

    always_comb
    begin
        cooling     = (cool_reg != '0);
        peak_upd    = ((s4_dev_reg > cfg.deviation_threshold)
                       && (peak_reg != cam_pkg::PEAK_CNT_MAX))
                    ? peak_reg + 1'b1 : peak_reg;
        wcnt_upd    = (wcnt_reg != cam_pkg::WINDOW_CNT_MAX) ? wcnt_reg + 1'b1 : wcnt_reg;
        trigger     = (peak_upd >= cfg.peaks_to_trigger);
        window_done = (wcnt_upd >= cfg.window_limit);
        do_ctl      = advance && s4_valid_reg && s4_warm_reg;

        peak_next = peak_reg;
        wcnt_next = wcnt_reg;
        cool_next = cool_reg;
        if (do_ctl)
        begin
            priority if (cooling)
            begin
                cool_next = cool_reg - 1'b1;
            end
            else if (trigger)
            begin
                peak_next = '0;
                wcnt_next = '0;
                cool_next = cfg.cooldown_limit;
            end
            else if (window_done)
            begin
                peak_next = '0;
                wcnt_next = '0;
            end
            else
            begin
                peak_next = peak_upd;
                wcnt_next = wcnt_upd;
            end
        end

        result_valid_next = advance ? (s4_valid_reg && s4_warm_reg) : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            seen_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            total_reg        <= '0;
            peak_reg         <= '0;
            wcnt_reg         <= '0;
            cool_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                pos_reg  <= (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                seen_reg <= warm0 ? seen_reg : seen_reg + 1'b1;
            end
            if (advance)
            begin
                s1_valid_reg <= q_pop;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                if (s1_valid_reg)
                begin
                    total_reg <= total_next;
                end
            end
            peak_reg         <= peak_next;
            wcnt_reg         <= wcnt_next;
            cool_reg         <= cool_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_amp_reg  <= q_data;
            s1_pos_reg  <= pos_reg;
            s1_warm_reg <= warm0;
            s2_amp_reg  <= s1_amp_reg;
            s2_warm_reg <= s1_warm_reg;
            s3_amp_reg  <= s2_amp_reg;
            s3_warm_reg <= s2_warm_reg;
            s3_prod_reg <= PROD_W'(total_reg) * PROD_W'(RECIP);
            s4_amp_reg  <= s3_amp_reg;
            s4_warm_reg <= s3_warm_reg;
            s4_avg_reg  <= avg;
            s4_dev_reg  <= (s3_amp_reg > avg) ? s3_amp_reg - avg : avg - s3_amp_reg;
            result_reg.frame_amplitude     <= s4_amp_reg;
            result_reg.window_average      <= s4_avg_reg;
            result_reg.amplitude_deviation <= s4_dev_reg;
            result_reg.motion_detected     <= !cooling && trigger;
            result_reg.cooling_down        <= cooling;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/csi_amplitude_motion_detector.sv =====
// ----------------------------------------------------------------------------
// csi_amplitude_motion_detector: CSI amplitude motion detector top level
// Frame accumulator, amplitude queue, detection pipeline and configuration.
// ----------------------------------------------------------------------------
// The block takes one I/Q sample pair every clock while sample_stall is low,
// and gives one result for each frame after the first WINDOW frames. After
// its last pair is taken, a frame passes the queue, then the ring read as the
// frame amplitude leaves the queue, running total, reciprocal multiply,
// deviation, counters and result register. A stalled result holds the whole
// detection pipeline; the four-entry queue keeps taking frames meanwhile and
// the input stalls only once it is full. The ring is a RAM of WINDOW entries
// that needs no clearing pass after reset; the block takes items from the
// first cycle out of reset. Configuration writes are taken in any cycle, and
// belong in idle periods only.
module csi_amplitude_motion_detector #(
    parameter int WINDOW    = 20,
    parameter int MAX_PAIRS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  cam_pkg::sample_t                  sample,
    output logic                              result_valid,
    input  logic                              result_stall,
    output cam_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cam_pkg::CFG_DATA_W-1:0]    cfg_data
);

    cam_pkg::cfg_t             cfg_reg, cfg_next;
    logic                      take;
    logic                      q_push, q_full, q_pop, q_empty;
    logic [cam_pkg::AMP_W-1:0] q_push_data, q_pop_data;

    assign cfg_ready    = 1'b1;
    assign sample_stall = q_full;
    assign take         = sample_valid && !sample_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cam_pkg::CFG_DEV_THRESHOLD: cfg_next.deviation_threshold = cfg_data[13:0];
                cam_pkg::CFG_PEAKS_TRIGGER: cfg_next.peaks_to_trigger    = cfg_data[7:0];
                cam_pkg::CFG_TIME_WINDOW:   cfg_next.window_limit        = cfg_data;
                cam_pkg::CFG_COOLDOWN:      cfg_next.cooldown_limit      = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deviation_threshold <= cam_pkg::RST_DEV_THRESHOLD;
            cfg_reg.peaks_to_trigger    <= cam_pkg::RST_PEAKS_TRIGGER;
            cfg_reg.window_limit        <= cam_pkg::RST_TIME_WINDOW;
            cfg_reg.cooldown_limit      <= cam_pkg::RST_COOLDOWN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cam_front #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .sample   (sample),
        .push     (q_push),
        .push_amp (q_push_data)
    );

    cam_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    cam_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_data       (q_pop_data),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("frame queue written while full");

    a_detect_not_cooling: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.motion_detected && result.cooling_down))
        else $error("detection reported on a cooldown frame");

    a_deviation_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.amplitude_deviation ==
            ((result.frame_amplitude > result.window_average)
             ? result.frame_amplitude - result.window_average
             : result.window_average - result.frame_amplitude)))
        else $error("deviation does not match amplitude and average");

endmodule
